// ===== src/njn_pkg.sv =====
package njn_pkg;

  localparam int unsigned MAX_RIGHT_ROWS = 16;
  localparam int unsigned MAX_COLUMNS    = 4;
  localparam int unsigned CELLS_IN       = 4;
  localparam int unsigned CELLS_OUT      = 7;
  localparam int unsigned CELL_W         = 32;
  localparam int unsigned ROW_W          = CELLS_IN * CELL_W;
  localparam int unsigned ADDR_W         = (MAX_RIGHT_ROWS > 1) ? $clog2(MAX_RIGHT_ROWS) : 1;
  localparam int unsigned CNT_W          = $clog2(MAX_RIGHT_ROWS + 1);
  localparam int unsigned COL_LIM        = (MAX_COLUMNS < CELLS_IN) ? MAX_COLUMNS : CELLS_IN;

  typedef enum logic [1:0] {
    CMD_STORE = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_PROBE = 2'd2
  } cmd_e;

  typedef enum logic {
    REG_KEY_COLUMN     = 1'b0,
    REG_COLUMNS_IN_USE = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    STAT_JOINED = 1'b0,
    STAT_FULL   = 1'b1
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FLUSH,
    S_REJECT
  } state_e;

  typedef struct packed {
    logic store_wr;
    logic clear;
    logic load_left;
    logic scan_start;
    logic scan_step;
    logic advance;
    logic capture;
    logic push;
    logic push_last;
    logic reject;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic scan_end;
    logic match;
    logic pend_valid;
    logic out_free;
  } dp_sts_t;

endpackage

// ===== src/njn_ram.sv =====
module njn_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/njn_ctrl.sv =====
module njn_ctrl
  import njn_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] command_i,
  input  dp_sts_t    sts_i,
  output dp_cmd_t    cmd_o
);

  state_e state_q, state_d;
  logic   in_acc;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (command_i)
            CMD_STORE: if (sts_i.full) state_d = S_REJECT;
            CMD_PROBE: state_d = S_SCAN;
            default:   state_d = S_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        if (sts_i.scan_end) state_d = S_FLUSH;
      end
      S_FLUSH: begin
        if (!sts_i.pend_valid || sts_i.out_free) state_d = S_IDLE;
      end
      S_REJECT: begin
        if (sts_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (command_i)
            CMD_STORE: cmd_o.store_wr = !sts_i.full;
            CMD_CLEAR: cmd_o.clear = 1'b1;
            CMD_PROBE: begin
              cmd_o.load_left  = 1'b1;
              cmd_o.scan_start = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (!sts_i.scan_end) begin
          if (!sts_i.match) begin
            cmd_o.advance = 1'b1;
          end else if (!sts_i.pend_valid) begin
            cmd_o.capture = 1'b1;
            cmd_o.advance = 1'b1;
          end else if (sts_i.out_free) begin
            cmd_o.push    = 1'b1;
            cmd_o.capture = 1'b1;
            cmd_o.advance = 1'b1;
          end
        end
      end
      S_FLUSH: begin
        cmd_o.push_last = sts_i.pend_valid && sts_i.out_free;
      end
      S_REJECT: begin
        cmd_o.reject = sts_i.out_free;
      end
      default: ;
    endcase
  end

endmodule

// ===== src/njn_dp.sv =====
module njn_dp
  import njn_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic signed [CELL_W-1:0] cell_0_i,
  input  logic signed [CELL_W-1:0] cell_1_i,
  input  logic signed [CELL_W-1:0] cell_2_i,
  input  logic signed [CELL_W-1:0] cell_3_i,
  input  logic                     cfg_valid_i,
  input  logic                     cfg_ready_i,
  input  logic                     cfg_index_i,
  input  logic [2:0]               cfg_wdata_i,
  input  logic                     out_stall_i,
  input  dp_cmd_t                  cmd_i,
  output dp_sts_t                  sts_o,
  output logic                     out_valid_o,
  output logic                     status_o,
  output logic signed [CELL_W-1:0] out_0_o,
  output logic signed [CELL_W-1:0] out_1_o,
  output logic signed [CELL_W-1:0] out_2_o,
  output logic signed [CELL_W-1:0] out_3_o,
  output logic signed [CELL_W-1:0] out_4_o,
  output logic signed [CELL_W-1:0] out_5_o,
  output logic signed [CELL_W-1:0] out_6_o,
  output logic                     last_o
);

  logic [1:0]        key_q;
  logic [2:0]        cols_q;
  logic [2:0]        eff_cols;
  logic              key_ok;
  logic [CNT_W-1:0]  cnt_q;
  logic [CNT_W-1:0]  rd_idx_q, rd_idx_d;
  logic [CNT_W-1:0]  rd_next;
  logic [ADDR_W-1:0] raddr;
  logic [ROW_W-1:0]  rdata;
  logic [ROW_W-1:0]  wdata;
  logic [CELL_W-1:0] left_q  [CELLS_IN];
  logic [CELL_W-1:0] right_c [CELLS_IN];
  logic [CELL_W-1:0] joined  [CELLS_OUT];
  logic [CELL_W-1:0] pend_q  [CELLS_OUT];
  logic              pend_v_q;
  logic [CELL_W-1:0] out_q   [CELLS_OUT];
  logic              out_v_q;
  logic              out_stat_q;
  logic              out_last_q;
  logic              out_free;

  assign eff_cols = (cols_q > 3'(COL_LIM)) ? 3'(COL_LIM) : cols_q;
  assign key_ok   = ({1'b0, key_q} < eff_cols);
  assign wdata    = {cell_3_i, cell_2_i, cell_1_i, cell_0_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q  <= 2'd0;
      cols_q <= 3'd3;
    end else if (cfg_valid_i && cfg_ready_i) begin
      case (cfg_index_i)
        REG_KEY_COLUMN:     key_q  <= cfg_wdata_i[1:0];
        REG_COLUMNS_IN_USE: cols_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.clear) begin
      cnt_q <= '0;
    end else if (cmd_i.store_wr) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  assign rd_next = rd_idx_q + 1'b1;

  always_comb begin
    rd_idx_d = rd_idx_q;
    if (cmd_i.scan_start) begin
      rd_idx_d = '0;
    end else if (cmd_i.advance) begin
      rd_idx_d = rd_next;
    end
  end

  assign raddr = rd_idx_d[ADDR_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q <= '0;
    end else begin
      rd_idx_q <= rd_idx_d;
    end
  end

  njn_ram #(
    .WIDTH(ROW_W),
    .DEPTH(MAX_RIGHT_ROWS)
  ) u_rows (
    .clk_i  (clk_i),
    .we_i   (cmd_i.store_wr),
    .waddr_i(cnt_q[ADDR_W-1:0]),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_left) begin
      left_q[0] <= cell_0_i;
      left_q[1] <= cell_1_i;
      left_q[2] <= cell_2_i;
      left_q[3] <= cell_3_i;
    end
  end

  always_comb begin
    for (int c = 0; c < CELLS_IN; c++) begin
      right_c[c] = rdata[c*CELL_W +: CELL_W];
    end
  end

  // left cells in use minus key column, then right cells in use, zero fill
  always_comb begin
    logic [2:0] pv;
    logic [2:0] src;
    logic [2:0] rc;
    logic [2:0] nl;
    nl = eff_cols - 3'd1;
    for (int p = 0; p < CELLS_OUT; p++) begin
      pv  = 3'(p);
      src = (pv < {1'b0, key_q}) ? pv : pv + 3'd1;
      rc  = pv - nl;
      if (pv < nl) begin
        joined[p] = left_q[src[1:0]];
      end else if (rc < eff_cols) begin
        joined[p] = right_c[rc[1:0]];
      end else begin
        joined[p] = '0;
      end
    end
  end

  assign out_free = !out_v_q || !out_stall_i;

  assign sts_o.full       = (cnt_q >= CNT_W'(MAX_RIGHT_ROWS));
  assign sts_o.scan_end   = (rd_idx_q == cnt_q);
  assign sts_o.match      = key_ok && (right_c[key_q] == left_q[key_q]);
  assign sts_o.pend_valid = pend_v_q;
  assign sts_o.out_free   = out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0;
    end else if (cmd_i.capture) begin
      pend_v_q <= 1'b1;
    end else if (cmd_i.push_last) begin
      pend_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      pend_q <= joined;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (cmd_i.push || cmd_i.push_last || cmd_i.reject) begin
      out_v_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.reject) begin
      out_stat_q <= STAT_FULL;
      out_last_q <= 1'b1;
      for (int p = 0; p < CELLS_OUT; p++) begin
        out_q[p] <= '0;
      end
    end else if (cmd_i.push || cmd_i.push_last) begin
      out_stat_q <= STAT_JOINED;
      out_last_q <= cmd_i.push_last;
      out_q      <= pend_q;
    end
  end

  assign out_valid_o = out_v_q;
  assign status_o    = out_stat_q;
  assign last_o      = out_last_q;
  assign out_0_o     = out_q[0];
  assign out_1_o     = out_q[1];
  assign out_2_o     = out_q[2];
  assign out_3_o     = out_q[3];
  assign out_4_o     = out_q[4];
  assign out_5_o     = out_q[5];
  assign out_6_o     = out_q[6];

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_RIGHT_ROWS))
    else $error("row count past table size");

  a_no_store_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.store_wr |-> (cnt_q < CNT_W'(MAX_RIGHT_ROWS)))
    else $error("store into full table");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan_step |-> (rd_idx_q <= cnt_q))
    else $error("scan index past row count");

  a_push_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.push || cmd_i.push_last) |-> (pend_v_q && out_free))
    else $error("push without pending row or free output");

  a_reject_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.reject |=> (out_v_q && out_last_q && (out_stat_q == STAT_FULL) &&
                      (out_q[0] == '0) && (out_q[6] == '0)))
    else $error("bad reject beat");

endmodule

// ===== src/nested_loop_equi_join_top.sv =====
// Equi-join engine. Store (command 0) writes one right row into a 16-row table; clear
// (command 1) empties it; a store into a full table yields one beat with status 1 and last
// set. A probe (command 2) reads the table through the single read port of the row RAM,
// one stored row compared per cycle unless a match waits on a stalled output; each matching
// row gives one beat (left cells without the key column, then the right cells, zero filled)
// and the final one has last set. No match, or a key column outside the columns in use,
// gives no beat. The input is stalled while an item is in progress; the result register
// lets the last beat wait while the next item is taken. Configuration writes are taken at
// any time but belong only in idle periods.
module nested_loop_equi_join_top
  import njn_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               command_i,
  input  logic signed [CELL_W-1:0] cell_0_i,
  input  logic signed [CELL_W-1:0] cell_1_i,
  input  logic signed [CELL_W-1:0] cell_2_i,
  input  logic signed [CELL_W-1:0] cell_3_i,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic                     cfg_index_i,
  input  logic [2:0]               cfg_wdata_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic                     status_o,
  output logic signed [CELL_W-1:0] out_0_o,
  output logic signed [CELL_W-1:0] out_1_o,
  output logic signed [CELL_W-1:0] out_2_o,
  output logic signed [CELL_W-1:0] out_3_o,
  output logic signed [CELL_W-1:0] out_4_o,
  output logic signed [CELL_W-1:0] out_5_o,
  output logic signed [CELL_W-1:0] out_6_o,
  output logic                     last_o
);

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  assign cfg_ready_o = 1'b1;

  njn_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .command_i (command_i),
    .sts_i     (dp_sts),
    .cmd_o     (dp_cmd)
  );

  njn_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cell_0_i   (cell_0_i),
    .cell_1_i   (cell_1_i),
    .cell_2_i   (cell_2_i),
    .cell_3_i   (cell_3_i),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_i(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i),
    .out_stall_i(out_stall_i),
    .cmd_i      (dp_cmd),
    .sts_o      (dp_sts),
    .out_valid_o(out_valid_o),
    .status_o   (status_o),
    .out_0_o    (out_0_o),
    .out_1_o    (out_1_o),
    .out_2_o    (out_2_o),
    .out_3_o    (out_3_o),
    .out_4_o    (out_4_o),
    .out_5_o    (out_5_o),
    .out_6_o    (out_6_o),
    .last_o     (last_o)
  );

endmodule
